@@ rtl/core/wti_pkg.sv @@
// shared widths, constants and shape codes for the window table interpolator
package wti_pkg;

    // field widths
    localparam int PHASE_W    = 17;
    localparam int GAIN_W     = 16;
    localparam int FRAC_W     = 16;
    localparam int SHAPE_W    = 2;
    localparam int PROD_W     = 32;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 16;

    // fixed point constants
    localparam logic [PHASE_W-1:0] PHASE_ONE = 17'h10000;
    localparam logic [FRAC_W:0]    FRAC_ONE  = 17'h10000;
    localparam logic [GAIN_W-1:0]  GAIN_ONE  = 16'h8000;
    localparam logic [PROD_W-1:0]  ROUND_HALF = 32'h0000_8000;

    // window shape codes
    localparam logic [SHAPE_W-1:0] SHAPE_HANN          = 2'd0;
    localparam logic [SHAPE_W-1:0] SHAPE_TRIANGLE      = 2'd1;
    localparam logic [SHAPE_W-1:0] SHAPE_TRAPEZOID     = 2'd2;
    localparam logic [SHAPE_W-1:0] SHAPE_TRAPEZOID_ALT = 2'd3;

endpackage

@@ rtl/core/wti_addr.sv @@
// phase saturation, scaling by the table span and index/fraction split
module wti_addr #(
    parameter int TABLE_SIZE = 512
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic                          in_valid,
    input  logic [wti_pkg::PHASE_W-1:0]   phase,
    output logic                          out_valid,
    output logic [$clog2(TABLE_SIZE)-1:0] idx_a,
    output logic [$clog2(TABLE_SIZE)-1:0] idx_b,
    output logic [wti_pkg::FRAC_W-1:0]    frac
);
    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int Q_W   = wti_pkg::PHASE_W + IDX_W;

    logic                       q_valid_reg;
    logic [Q_W-1:0]             q_reg;
    logic [Q_W-1:0]             q_next;
    logic [wti_pkg::PHASE_W-1:0] p_sat;

    logic                       a_valid_reg;
    logic [IDX_W-1:0]           idx_a_reg;
    logic [IDX_W-1:0]           idx_a_next;
    logic [IDX_W-1:0]           idx_b_reg;
    logic [wti_pkg::FRAC_W-1:0] frac_reg;
    logic [IDX_W:0]             idx_full;

    // saturate to one and scale by the table span
    always_comb begin
        p_sat  = (phase > wti_pkg::PHASE_ONE) ? wti_pkg::PHASE_ONE : phase;
        q_next = Q_W'(p_sat) * Q_W'(TABLE_SIZE - 1);
    end

    // stage one: scaled phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_valid_reg <= 1'b0;
        end else if (advance) begin
            q_valid_reg <= in_valid;
        end
        if (advance) begin
            q_reg <= q_next;
        end
    end

    // index clamp, the fraction is kept from before the clamp
    always_comb begin
        idx_full = q_reg[Q_W-1:wti_pkg::FRAC_W];
        if (idx_full > (IDX_W+1)'(TABLE_SIZE - 2)) begin
            idx_a_next = IDX_W'(TABLE_SIZE - 2);
        end else begin
            idx_a_next = idx_full[IDX_W-1:0];
        end
    end

    // stage two: entry addresses and fraction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (advance) begin
            a_valid_reg <= q_valid_reg;
        end
        if (advance) begin
            idx_a_reg <= idx_a_next;
            idx_b_reg <= idx_a_next + IDX_W'(1);
            frac_reg  <= q_reg[wti_pkg::FRAC_W-1:0];
        end
    end

    assign out_valid = a_valid_reg;
    assign idx_a     = idx_a_reg;
    assign idx_b     = idx_b_reg;
    assign frac      = frac_reg;

endmodule

@@ rtl/core/wti_rom.sv @@
// window shape tables built at elaboration, read at two addresses per cycle
module wti_rom #(
    parameter int TABLE_SIZE = 512
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic [wti_pkg::SHAPE_W-1:0]   shape,
    input  logic                          in_valid,
    input  logic [$clog2(TABLE_SIZE)-1:0] idx_a,
    input  logic [$clog2(TABLE_SIZE)-1:0] idx_b,
    input  logic [wti_pkg::FRAC_W-1:0]    frac_in,
    output logic                          out_valid,
    output logic [wti_pkg::GAIN_W-1:0]    entry_a,
    output logic [wti_pkg::GAIN_W-1:0]    entry_b,
    output logic [wti_pkg::FRAC_W-1:0]    frac_out
);
    localparam logic [63:0] DEN = 64'(TABLE_SIZE - 1);
    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;

    logic [wti_pkg::GAIN_W-1:0] hann_rom [TABLE_SIZE];
    logic [wti_pkg::GAIN_W-1:0] tri_rom  [TABLE_SIZE];
    logic [wti_pkg::GAIN_W-1:0] trap_rom [TABLE_SIZE];

    logic                       valid_reg;
    logic [wti_pkg::GAIN_W-1:0] entry_a_reg;
    logic [wti_pkg::GAIN_W-1:0] entry_b_reg;
    logic [wti_pkg::FRAC_W-1:0] frac_reg;

    // table contents, one entry per position
    for (genvar i = 0; i < TABLE_SIZE; i++) begin : g_entry
        localparam logic [63:0] I = 64'(i);
        // hann: sine in Q30 by a truncating series, then squared
        localparam logic [63:0] J  = (I <= DEN - I) ? I : DEN - I;
        localparam logic [63:0] X  = (PI_Q30 * J + DEN / 2) / DEN;
        localparam logic [63:0] X2 = (X * X) >> 30;
        localparam logic [63:0] T1 = ((X  * X2) >> 30) / 64'd6;
        localparam logic [63:0] T2 = ((T1 * X2) >> 30) / 64'd20;
        localparam logic [63:0] T3 = ((T2 * X2) >> 30) / 64'd42;
        localparam logic [63:0] T4 = ((T3 * X2) >> 30) / 64'd72;
        localparam logic [63:0] T5 = ((T4 * X2) >> 30) / 64'd110;
        localparam logic [63:0] T6 = ((T5 * X2) >> 30) / 64'd156;
        localparam logic [63:0] T7 = ((T6 * X2) >> 30) / 64'd210;
        localparam logic [63:0] T8 = ((T7 * X2) >> 30) / 64'd272;
        localparam logic [63:0] T9 = ((T8 * X2) >> 30) / 64'd342;
        localparam logic [63:0] POS = X + T2 + T4 + T6 + T8;
        localparam logic [63:0] NEG = T1 + T3 + T5 + T7 + T9;
        localparam logic [63:0] S0  = (POS > NEG) ? POS - NEG : 64'd0;
        localparam logic [63:0] S   = (S0 > Q30_ONE) ? Q30_ONE : S0;
        localparam logic [63:0] G   = (S * S + (64'd1 << 44)) >> 45;
        localparam logic [63:0] HV  = (G > 64'd32768) ? 64'd32768 : G;
        // triangle: rising then falling about the centre
        localparam logic [63:0] TV  = (2 * I < DEN) ?
            (64'd65536 * I + DEN / 2) / DEN :
            (64'd65536 * (DEN - I) + DEN / 2) / DEN;
        // trapezoid: ramps over the outer quarters, flat top between
        localparam logic [63:0] ZV  = (4 * I < DEN) ?
            (64'd131072 * I + DEN / 2) / DEN :
            ((4 * I > 3 * DEN) ?
            (64'd131072 * (DEN - I) + DEN / 2) / DEN : 64'd32768);

        assign hann_rom[i] = HV[wti_pkg::GAIN_W-1:0];
        assign tri_rom[i]  = TV[wti_pkg::GAIN_W-1:0];
        assign trap_rom[i] = ZV[wti_pkg::GAIN_W-1:0];
    end

    // stage three: registered table reads for the selected shape
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
        if (advance) begin
            frac_reg <= frac_in;
            unique case (shape) inside
                wti_pkg::SHAPE_HANN: begin
                    entry_a_reg <= hann_rom[idx_a];
                    entry_b_reg <= hann_rom[idx_b];
                end
                wti_pkg::SHAPE_TRIANGLE: begin
                    entry_a_reg <= tri_rom[idx_a];
                    entry_b_reg <= tri_rom[idx_b];
                end
                wti_pkg::SHAPE_TRAPEZOID, wti_pkg::SHAPE_TRAPEZOID_ALT: begin
                    entry_a_reg <= trap_rom[idx_a];
                    entry_b_reg <= trap_rom[idx_b];
                end
            endcase
        end
    end

    assign out_valid = valid_reg;
    assign entry_a   = entry_a_reg;
    assign entry_b   = entry_b_reg;
    assign frac_out  = frac_reg;

endmodule

@@ rtl/core/wti_blend.sv @@
// linear blend of two adjacent entries with round to nearest
module wti_blend (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       advance,
    input  logic                       in_valid,
    input  logic [wti_pkg::GAIN_W-1:0] entry_a,
    input  logic [wti_pkg::GAIN_W-1:0] entry_b,
    input  logic [wti_pkg::FRAC_W-1:0] frac,
    output logic                       out_valid,
    output logic [wti_pkg::GAIN_W-1:0] gain
);
    logic                       prod_valid_reg;
    logic [wti_pkg::PROD_W-1:0] prod_a_reg;
    logic [wti_pkg::PROD_W-1:0] prod_b_reg;
    logic [wti_pkg::FRAC_W:0]   weight_a;

    logic                       gain_valid_reg;
    logic [wti_pkg::GAIN_W-1:0] gain_reg;
    logic [wti_pkg::PROD_W-1:0] sum;

    // weight of the lower entry
    assign weight_a = wti_pkg::FRAC_ONE - (wti_pkg::FRAC_W+1)'(frac);

    // stage four: the two weighted products
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else if (advance) begin
            prod_valid_reg <= in_valid;
        end
        if (advance) begin
            prod_a_reg <= wti_pkg::PROD_W'(entry_a) * wti_pkg::PROD_W'(weight_a);
            prod_b_reg <= wti_pkg::PROD_W'(entry_b) * wti_pkg::PROD_W'(frac);
        end
    end

    // sum stays below 2^32 since the weights add to one
    assign sum = prod_a_reg + prod_b_reg + wti_pkg::ROUND_HALF;

    // stage five: rounded gain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_valid_reg <= 1'b0;
        end else if (advance) begin
            gain_valid_reg <= prod_valid_reg;
        end
        if (advance) begin
            gain_reg <= sum[wti_pkg::PROD_W-1:wti_pkg::FRAC_W];
        end
    end

    assign out_valid = gain_valid_reg;
    assign gain      = gain_reg;

endmodule

@@ rtl/core/wti_skid.sv @@
// output register with a skid slot, keeps the input side ready registered
module wti_skid (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    input  logic [wti_pkg::GAIN_W-1:0] in_data,
    output logic                       in_ready,
    output logic                       out_valid,
    output logic [wti_pkg::GAIN_W-1:0] out_data,
    input  logic                       out_ready
);
    logic                       out_valid_reg;
    logic [wti_pkg::GAIN_W-1:0] out_data_reg;
    logic                       skid_valid_reg;
    logic [wti_pkg::GAIN_W-1:0] skid_data_reg;
    logic                       in_fire;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && !skid_valid_reg;

    // output slot refills from the skid slot first
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                out_data_reg   <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_fire;
                out_data_reg  <= in_data;
            end
        end else if (in_fire) begin
            skid_valid_reg <= 1'b1;
            skid_data_reg  <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ rtl/core/window_table_interpolator.sv @@
// top level of the window table interpolator: phase in, window gain out
// path to m_tvalid: phase, address, table, product, gain and output registers
// throughput: one request per cycle while the skid slot is free, set by the
// five-stage pipeline and the two-address table read in stage three
// reset: aresetn low clears all valid bits, empties the output and skid slots
// and sets the window shape to hann
module window_table_interpolator #(
    parameter int TABLE_SIZE = 512
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration
    input  logic                             cfg_wr_en,
    input  logic [wti_pkg::SHAPE_W-1:0]      cfg_wr_data,  // window_shape
    // phase requests
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [wti_pkg::S_TDATA_W-1:0]    s_tdata,      // [16:0] phase, rest zero
    // gain results
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [wti_pkg::M_TDATA_W-1:0]    m_tdata       // [15:0] gain
);
    localparam int IDX_W = $clog2(TABLE_SIZE);

    logic [wti_pkg::SHAPE_W-1:0] shape_reg;
    logic                        advance;

    logic                        addr_valid;
    logic [IDX_W-1:0]            idx_a;
    logic [IDX_W-1:0]            idx_b;
    logic [wti_pkg::FRAC_W-1:0]  addr_frac;

    logic                        rom_valid;
    logic [wti_pkg::GAIN_W-1:0]  entry_a;
    logic [wti_pkg::GAIN_W-1:0]  entry_b;
    logic [wti_pkg::FRAC_W-1:0]  rom_frac;

    logic                        gain_valid;
    logic [wti_pkg::GAIN_W-1:0]  gain;
    logic                        skid_ready;
    logic [wti_pkg::GAIN_W-1:0]  out_gain;

    // shape register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shape_reg <= wti_pkg::SHAPE_HANN;
        end else if (cfg_wr_en) begin
            shape_reg <= cfg_wr_data;
        end
    end

    // whole pipeline moves while the skid slot is free
    assign advance  = skid_ready;
    assign s_tready = skid_ready;

    wti_addr #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_addr (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (s_tvalid),
        .phase     (s_tdata[wti_pkg::PHASE_W-1:0]),
        .out_valid (addr_valid),
        .idx_a     (idx_a),
        .idx_b     (idx_b),
        .frac      (addr_frac)
    );

    wti_rom #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_rom (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .shape     (shape_reg),
        .in_valid  (addr_valid),
        .idx_a     (idx_a),
        .idx_b     (idx_b),
        .frac_in   (addr_frac),
        .out_valid (rom_valid),
        .entry_a   (entry_a),
        .entry_b   (entry_b),
        .frac_out  (rom_frac)
    );

    wti_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (rom_valid),
        .entry_a   (entry_a),
        .entry_b   (entry_b),
        .frac      (rom_frac),
        .out_valid (gain_valid),
        .gain      (gain)
    );

    wti_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (gain_valid && advance),
        .in_data   (gain),
        .in_ready  (skid_ready),
        .out_valid (m_tvalid),
        .out_data  (out_gain),
        .out_ready (m_tready)
    );

    assign m_tdata = wti_pkg::M_TDATA_W'(out_gain);

endmodule

@@ rtl/core/wti_checker.sv @@
// port-level checks for the window table interpolator and their binding
module wti_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [wti_pkg::M_TDATA_W-1:0] m_tdata
);
    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result request dropped while stalled");

    // gain never exceeds one
    a_gain_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata <= wti_pkg::M_TDATA_W'(wti_pkg::GAIN_ONE)))
        else $error("gain above one");

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

    // the input side only blocks while a result is held back
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && $past(m_tvalid) && !$past(m_tready))
        else $error("input blocked without an output stall");

endmodule

bind window_table_interpolator wti_checker u_wti_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/window_table_interpolator_test.sv @@
// self-checking testbench for the window table interpolator: phase requests in, gains checked
`timescale 1ns / 1ps

module window_table_interpolator_test;

    localparam int TABLE_SIZE = 512;
    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int CLK_HALF = 6;
    localparam int RESET_CYCLES = 5;
    localparam int DRAIN_CYCLES = 8;
    localparam int END_CYCLES = 20;
    localparam int QUIET_LIMIT = 4000;
    localparam int LONG_HOLD = 300;
    localparam int PHASE_ITEMS = 240;
    localparam int NUM_PHASES = 8;
    localparam int MAX_REPORTS = 10;
    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam longint Q30_ONE = 64'sd1073741824;

    typedef struct packed {
        logic [wti_pkg::PHASE_W-1:0] phase;
        logic [wti_pkg::GAIN_W-1:0]  gain;
    } gain_entry_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [wti_pkg::SHAPE_W-1:0] cfg_wr_data = wti_pkg::SHAPE_HANN;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [wti_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [wti_pkg::M_TDATA_W-1:0] m_tdata;

    // predictor state and bookkeeping
    logic [wti_pkg::GAIN_W-1:0] window_rom [4][TABLE_SIZE];
    logic [wti_pkg::SHAPE_W-1:0] shape_now = wti_pkg::SHAPE_HANN;
    logic [wti_pkg::PHASE_W-1:0] phase_backlog [$];
    gain_entry_t gain_expected [$];
    bit tx_gaps_on = 1'b1;
    bit rx_gaps_on = 1'b1;
    int tx_gap_left = 0;
    int rx_gap_left = 0;
    int requests_sent = 0;
    int gains_checked = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    window_table_interpolator #(
        .TABLE_SIZE(TABLE_SIZE)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),    // [16:0] phase, [23:17] zero
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)     // [15:0] gain
    );

    // clock
    initial begin
        forever begin
            #CLK_HALF aclk = ~aclk;
        end
    end

    function automatic longint unsigned round_div(longint unsigned num, longint unsigned den);
        return (num + den / 2) / den;
    endfunction

    // hann entry: sin^2 via a q30 taylor series, mirrored about the centre
    function automatic logic [wti_pkg::GAIN_W-1:0] hann_point(int unsigned i);
        longint unsigned d, j, x, x2, t, g;
        longint s;
        int unsigned k;
        d = 64'(TABLE_SIZE - 1);
        j = (64'(i) <= d - 64'(i)) ? 64'(i) : d - 64'(i);
        x = (PI_Q30 * j + d / 2) / d;
        x2 = (x * x) >> 30;
        t = x;
        s = longint'(x);
        for (k = 1; k <= 9; k++) begin
            t = ((t * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k[0])
                s = s - longint'(t);
            else
                s = s + longint'(t);
        end
        if (s < 0)
            s = 0;
        if (s > Q30_ONE)
            s = Q30_ONE;
        g = (longint'(s) * longint'(s) + (64'd1 << 44)) >> 45;
        return (g > wti_pkg::GAIN_ONE) ? wti_pkg::GAIN_ONE : g[wti_pkg::GAIN_W-1:0];
    endfunction

    // one table entry for a given shape code
    function automatic logic [wti_pkg::GAIN_W-1:0] window_point(
        logic [wti_pkg::SHAPE_W-1:0] shape, int unsigned i);
        longint unsigned d;
        d = 64'(TABLE_SIZE - 1);
        if (shape == wti_pkg::SHAPE_HANN)
            return hann_point(i);
        if (shape == wti_pkg::SHAPE_TRIANGLE) begin
            if (2 * longint'(i) < d)
                return wti_pkg::GAIN_W'(round_div(65536 * longint'(i), d));
            return wti_pkg::GAIN_W'(round_div(65536 * (d - 64'(i)), d));
        end
        if (4 * longint'(i) < d)
            return wti_pkg::GAIN_W'(round_div(131072 * longint'(i), d));
        if (4 * longint'(i) > 3 * d)
            return wti_pkg::GAIN_W'(round_div(131072 * (d - 64'(i)), d));
        return wti_pkg::GAIN_ONE;
    endfunction

    // interpolated gain: fraction taken before the index clamp
    function automatic logic [wti_pkg::GAIN_W-1:0] predict_gain(
        logic [wti_pkg::SHAPE_W-1:0] shape, logic [wti_pkg::PHASE_W-1:0] phase);
        longint unsigned p, q, f, a, b, sum;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] idx_up;
        p = (phase > wti_pkg::PHASE_ONE) ? 64'(wti_pkg::PHASE_ONE) : 64'(phase);
        q = p * 64'(TABLE_SIZE - 1);
        f = q & 64'hFFFF;
        if ((q >> 16) > 64'(TABLE_SIZE - 2))
            idx = IDX_W'(TABLE_SIZE - 2);
        else
            idx = IDX_W'(q >> 16);
        idx_up = idx + IDX_W'(1);
        a = 64'(window_rom[shape][idx]);
        b = 64'(window_rom[shape][idx_up]);
        sum = (a * (65536 - f) + b * f + 32768) >> 16;
        return sum[wti_pkg::GAIN_W-1:0];
    endfunction

    // random phase, weighted toward the saturation point, zero and table knots
    function automatic logic [wti_pkg::PHASE_W-1:0] random_phase();
        int unsigned r, k;
        r = $urandom_range(0, 99);
        if (r < 55)
            return wti_pkg::PHASE_W'($urandom_range(0, wti_pkg::PHASE_ONE));
        if (r < 70)
            return wti_pkg::PHASE_W'($urandom_range(0, (1 << wti_pkg::PHASE_W) - 1));
        if (r < 80)
            return wti_pkg::PHASE_W'($urandom_range(wti_pkg::PHASE_ONE - 16,
                                                    wti_pkg::PHASE_ONE + 4));
        if (r < 88)
            return wti_pkg::PHASE_W'($urandom_range(0, 40));
        k = $urandom_range(0, TABLE_SIZE - 1);
        return wti_pkg::PHASE_W'((k * 65536) / (TABLE_SIZE - 1) + $urandom_range(0, 2));
    endfunction

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            tx_gap_left <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                gain_expected.push_back('{phase: s_tdata[wti_pkg::PHASE_W-1:0],
                    gain: predict_gain(shape_now, s_tdata[wti_pkg::PHASE_W-1:0])});
                requests_sent <= requests_sent + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap_left > 0) begin
                    s_tvalid <= 1'b0;
                    tx_gap_left <= tx_gap_left - 1;
                end else if (phase_backlog.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {{(wti_pkg::S_TDATA_W - wti_pkg::PHASE_W){1'b0}},
                                phase_backlog.pop_front()};
                    tx_gap_left <= tx_gaps_on ? $urandom_range(0, 7) : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge aclk) begin
        gain_entry_t want;
        int hold;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap_left <= 0;
        end else begin
            hold = rx_gap_left;
            if (m_tvalid && m_tready) begin
                if (gain_expected.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < MAX_REPORTS)
                        $display("unexpected gain %0d with no request waiting", m_tdata);
                end else begin
                    want = gain_expected.pop_front();
                    if (m_tdata !== want.gain) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < MAX_REPORTS)
                            $display("gain mismatch at result %0d: phase %05h expected %0d got %0d",
                                     gains_checked, want.phase, want.gain, m_tdata);
                    end
                end
                gains_checked <= gains_checked + 1;
                if (gains_checked == 600 || gains_checked == 1550)
                    hold = LONG_HOLD;
                else
                    hold = rx_gaps_on ? $urandom_range(0, 7) : 0;
            end
            if (hold > 0) begin
                m_tready <= 1'b0;
                rx_gap_left <= hold - 1;
            end else begin
                m_tready <= 1'b1;
                rx_gap_left <= 0;
            end
        end
    end

    // cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(negedge aclk);
        $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
        $display("FAIL window_table_interpolator");
        $finish;
    end

    // wait until every request has come back, then let the pipeline settle
    task automatic wait_drained();
        @(negedge aclk);
        while (phase_backlog.size() > 0 || s_tvalid || gain_expected.size() > 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_shape(logic [wti_pkg::SHAPE_W-1:0] shape);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= shape;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        shape_now = shape;
    endtask

    // stimulus sequence
    initial begin
        logic [wti_pkg::SHAPE_W-1:0] directed_shapes [4];
        logic [wti_pkg::SHAPE_W-1:0] phase_shapes [NUM_PHASES];
        bit phase_tx_gaps [NUM_PHASES];
        bit phase_rx_gaps [NUM_PHASES];
        logic [wti_pkg::PHASE_W-1:0] corner_phases [6];
        int s, n, ph;

        directed_shapes = '{wti_pkg::SHAPE_HANN, wti_pkg::SHAPE_TRIANGLE,
                            wti_pkg::SHAPE_TRAPEZOID, wti_pkg::SHAPE_TRAPEZOID_ALT};
        phase_shapes = '{wti_pkg::SHAPE_TRIANGLE, wti_pkg::SHAPE_TRAPEZOID,
                         wti_pkg::SHAPE_HANN, wti_pkg::SHAPE_TRAPEZOID_ALT,
                         wti_pkg::SHAPE_HANN, wti_pkg::SHAPE_TRIANGLE,
                         wti_pkg::SHAPE_TRAPEZOID, wti_pkg::SHAPE_HANN};
        phase_tx_gaps = '{1, 1, 0, 1, 0, 1, 0, 1};
        phase_rx_gaps = '{1, 0, 1, 1, 0, 0, 1, 1};
        // zero, just below one, exactly one, just above one, all ones, one half
        corner_phases = '{17'h00000, 17'h0FFFF, 17'h10000, 17'h10001, 17'h1FFFF, 17'h08000};

        for (s = 0; s < 4; s++)
            for (n = 0; n < TABLE_SIZE; n++)
                window_rom[s[wti_pkg::SHAPE_W-1:0]][n[IDX_W-1:0]] =
                    window_point(s[wti_pkg::SHAPE_W-1:0], n);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // directed corners, first pass on the reset shape
        for (s = 0; s < 4; s++) begin
            if (s > 0)
                write_shape(directed_shapes[s[1:0]]);
            @(negedge aclk);
            foreach (corner_phases[n])
                phase_backlog.push_back(corner_phases[n]);
            wait_drained();
        end

        // random phases under each shape and idling mix
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            write_shape(phase_shapes[ph[2:0]]);
            @(negedge aclk);
            tx_gaps_on = phase_tx_gaps[ph[2:0]];
            rx_gaps_on = phase_rx_gaps[ph[2:0]];
            for (n = 0; n < PHASE_ITEMS; n++)
                phase_backlog.push_back(random_phase());
            wait_drained();
        end

        repeat (END_CYCLES) @(posedge aclk);
        $display("%0d phase requests over hann, triangle and both trapezoid codes, %0d gains checked",
                 requests_sent, gains_checked);
        $display("with saturated phases, random gaps on both sides and long result hold-offs");
        if (mismatches == 0 && gain_expected.size() == 0) begin
            $display("PASS window_table_interpolator");
        end else begin
            $display("%0d mismatches, %0d gains still expected", mismatches, gain_expected.size());
            $display("FAIL window_table_interpolator");
        end
        $finish;
    end

endmodule
